### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the min-tracking stack.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MTS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("mts assertion failed");

// Condition must never be true at a clock edge outside reset.
`define MTS_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("mts forbidden condition seen");

`endif

### rtl/core/mts_pkg.sv
// Package for the min-tracking stack: sizes, operation and status codes, FSM type.
// Depends on nothing; imported by the top level and the testbench.
package mts_pkg;

	localparam int DEPTH  = 1024;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_PUSH_FULL = 2'd1;
	localparam logic [1:0] ST_POP_EMPTY = 2'd2;

	typedef enum logic {
		FSM_IDLE,
		FSM_EXEC
	} fsm_state_t;

endpackage

### rtl/core/mts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; instantiated for the value and minimum stores.
module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/min_tracking_stack_top.sv
// Top level of the min-tracking stack: control FSM, counters and output register.
// Depends on mts_pkg, mts_ram and assert_macros.svh.
// An accepted word is captured while both stores are read; its result is registered on execute.
// A new word is not accepted while the previous one is still in the execute state.
// A waiting result does not block acceptance; execution waits for the output register.
// Reset clears the counts and FSM; the stores need no clearing pass.
`include "assert_macros.svh"

module min_tracking_stack_top
	import mts_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     kind,
	input  logic signed [WORD_W-1:0] operand,
	input  logic                     last_op,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WORD_W-1:0] minimum,
	output logic                     is_empty,
	output logic [1:0]               status
);

	fsm_state_t state_q, state_nxt;

	logic [CNT_W-1:0]         vc_q, mc_q;
	logic signed [WORD_W-1:0] min_top_q;
	logic                     out_valid_q;

	logic                     kind_s1, last_s1;
	logic signed [WORD_W-1:0] operand_s1;

	logic [CNT_W-1:0]  vc_dec, mc_dec, mc_dec2;
	logic              rd_en, exec_fire, in_fire;
	logic [WORD_W-1:0] val_rdata, min_rdata;

	logic                     val_we, min_we;
	logic [CNT_W-1:0]         vc_new, mc_new;
	logic signed [WORD_W-1:0] top_new;
	logic [1:0]               status_new;

	assign vc_dec  = vc_q - CNT_W'(1);
	assign mc_dec  = mc_q - CNT_W'(1);
	assign mc_dec2 = mc_q - CNT_W'(2);
	assign in_fire = in_valid && !in_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (in_valid) begin
					state_nxt = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (!out_valid_q || !out_stall) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: state_nxt = FSM_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		rd_en     = 1'b0;
		exec_fire = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				in_stall = 1'b0;
				rd_en    = in_valid;
			end
			FSM_EXEC: begin
				exec_fire = !out_valid_q || !out_stall;
			end
			default: in_stall = 1'b1;
		endcase
	end

	mts_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (vc_q[ADDR_W-1:0]),
		.wdata (operand_s1),
		.re    (rd_en),
		.raddr (vc_dec[ADDR_W-1:0]),
		.rdata (val_rdata)
	);

	mts_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_min_ram (
		.clk   (clk),
		.we    (min_we),
		.waddr (mc_q[ADDR_W-1:0]),
		.wdata (operand_s1),
		.re    (rd_en),
		.raddr (mc_dec2[ADDR_W-1:0]),
		.rdata (min_rdata)
	);

	always_comb begin
		val_we     = 1'b0;
		min_we     = 1'b0;
		vc_new     = vc_q;
		mc_new     = mc_q;
		top_new    = min_top_q;
		status_new = ST_OK;
		if (kind_s1 == KIND_PUSH) begin
			if (vc_q == CNT_W'(DEPTH)) begin
				status_new = ST_PUSH_FULL;
			end else begin
				val_we = exec_fire;
				vc_new = vc_q + CNT_W'(1);
				if (mc_q == '0 || min_top_q >= operand_s1) begin
					min_we  = exec_fire;
					mc_new  = mc_q + CNT_W'(1);
					top_new = operand_s1;
				end
			end
		end else begin
			if (vc_q == '0) begin
				status_new = ST_POP_EMPTY;
			end else begin
				vc_new = vc_dec;
				if (mc_q != '0 && min_top_q == $signed(val_rdata)) begin
					mc_new  = mc_dec;
					top_new = $signed(min_rdata);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			vc_q        <= '0;
			mc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (exec_fire) begin
				out_valid_q <= 1'b1;
				vc_q        <= last_s1 ? '0 : vc_new;
				mc_q        <= last_s1 ? '0 : mc_new;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1    <= kind;
			operand_s1 <= operand;
			last_s1    <= last_op;
		end
		if (exec_fire) begin
			min_top_q <= top_new;
			minimum   <= (vc_new != '0 && mc_new != '0) ? top_new : '0;
			is_empty  <= (vc_new == '0);
			status    <= status_new;
		end
	end

	assign out_valid = out_valid_q;

	`MTS_ASSERT(a_min_le_val, clk, arst_n, mc_q <= vc_q)
	`MTS_ASSERT(a_val_in_range, clk, arst_n, vc_q <= CNT_W'(DEPTH))
	`MTS_ASSERT(a_result_from_exec, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == FSM_EXEC))
	`MTS_NEVER(a_no_write_on_read, clk, arst_n, rd_en && (val_we || min_we))

endmodule

### dv/tb.sv
// Testbench for min_tracking_stack_top: a directed table, random push/pop sequences
// and a fill-to-full pass, checked against a stack predictor or, for typed rows, the table.
// Depends on mts_pkg and the RTL of the min-tracking stack.
module tb;
	import mts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [WORD_W-1:0] W_MIN = 32'sh8000_0000;
	localparam logic signed [WORD_W-1:0] W_MAX = 32'sh7fff_ffff;
	localparam int RANDOM_ITEMS = 800;
	localparam int FULL_POPS = 6;

	typedef struct packed {
		logic signed [WORD_W-1:0] minimum;
		logic                     is_empty;
		logic [1:0]               status;
	} stack_result_t;

	typedef struct packed {
		logic                     kind;
		logic signed [WORD_W-1:0] operand;
		logic                     last_op;
		bit                       typed;
		stack_result_t            res;
	} dir_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     kind = KIND_PUSH;
	logic signed [WORD_W-1:0] operand = '0;
	logic                     last_op = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [WORD_W-1:0] minimum;
	logic                     is_empty;
	logic [1:0]               status;

	logic signed [WORD_W-1:0] value_mirror [DEPTH];
	logic signed [WORD_W-1:0] min_mirror [DEPTH];
	int                       value_used = 0;
	int                       min_used = 0;

	stack_result_t pending_results [$];
	int            fail_count = 0;
	int            send_idle_pct = 30;
	int            recv_stall_pct = 56;

	dir_row_t dir_rows [22] = '{
		'{KIND_POP,  32'sd0,  1'b0, 1'b1, '{32'sd0, 1'b1, ST_POP_EMPTY}},
		'{KIND_PUSH, W_MIN,   1'b0, 1'b1, '{W_MIN,  1'b0, ST_OK}},
		'{KIND_PUSH, W_MAX,   1'b0, 1'b1, '{W_MIN,  1'b0, ST_OK}},
		'{KIND_PUSH, W_MIN,   1'b0, 1'b1, '{W_MIN,  1'b0, ST_OK}},
		'{KIND_POP,  32'sd0,  1'b0, 1'b1, '{W_MIN,  1'b0, ST_OK}},
		'{KIND_POP,  W_MAX,   1'b0, 1'b1, '{W_MIN,  1'b0, ST_OK}},
		'{KIND_POP,  W_MIN,   1'b1, 1'b1, '{32'sd0, 1'b1, ST_OK}},
		'{KIND_POP,  32'sd0,  1'b0, 1'b1, '{32'sd0, 1'b1, ST_POP_EMPTY}},
		'{KIND_PUSH, 32'sd0,  1'b0, 1'b1, '{32'sd0, 1'b0, ST_OK}},
		'{KIND_PUSH, -32'sd1, 1'b0, 1'b1, '{-32'sd1, 1'b0, ST_OK}},
		'{KIND_PUSH, 32'sd7,  1'b0, 1'b0, '0},
		'{KIND_PUSH, -32'sd1, 1'b0, 1'b0, '0},
		'{KIND_POP,  32'sd0,  1'b0, 1'b0, '0},
		'{KIND_POP,  -32'sd1, 1'b0, 1'b0, '0},
		'{KIND_POP,  32'sd0,  1'b0, 1'b0, '0},
		'{KIND_POP,  32'sd0,  1'b1, 1'b0, '0},
		'{KIND_PUSH, W_MAX,   1'b1, 1'b1, '{W_MAX,  1'b0, ST_OK}},
		'{KIND_POP,  32'sd0,  1'b1, 1'b1, '{32'sd0, 1'b1, ST_POP_EMPTY}},
		'{KIND_PUSH, 32'sd5,  1'b0, 1'b0, '0},
		'{KIND_PUSH, 32'sd3,  1'b0, 1'b0, '0},
		'{KIND_POP,  W_MAX,   1'b0, 1'b0, '0},
		'{KIND_POP,  32'sd0,  1'b1, 1'b0, '0}
	};

	min_tracking_stack_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.operand   (operand),
		.last_op   (last_op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.minimum   (minimum),
		.is_empty  (is_empty),
		.status    (status)
	);

	always #1 clk = ~clk;

	task automatic track_min_stack(input logic k, input logic signed [WORD_W-1:0] v,
		input logic l, output stack_result_t r);
		logic signed [WORD_W-1:0] popped;
		r.status = ST_OK;
		if (k == KIND_PUSH) begin
			if (value_used >= DEPTH) begin
				r.status = ST_PUSH_FULL;
			end else begin
				value_mirror[value_used] = v;
				value_used++;
				if (min_used == 0 || min_mirror[min_used - 1] >= v) begin
					if (min_used < DEPTH) begin
						min_mirror[min_used] = v;
						min_used++;
					end
				end
			end
		end else if (value_used == 0) begin
			r.status = ST_POP_EMPTY;
		end else begin
			value_used--;
			popped = value_mirror[value_used];
			if (min_used > 0 && min_mirror[min_used - 1] == popped) begin
				min_used--;
			end
		end
		r.minimum = (value_used > 0 && min_used > 0) ? min_mirror[min_used - 1] : '0;
		r.is_empty = (value_used == 0);
		if (l) begin
			value_used = 0;
			min_used = 0;
		end
	endtask

	function automatic logic signed [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: begin
				return W_MIN;
			end
			1: begin
				return W_MAX;
			end
			2, 3, 4: begin
				return int'($urandom_range(0, 8)) - 4;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic issue_word(input logic k, input logic signed [WORD_W-1:0] v, input logic l,
		input bit typed, input stack_result_t typed_res);
		stack_result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		operand <= v;
		last_op <= l;
		do @(posedge clk); while (in_stall);
		track_min_stack(k, v, l, r);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected word: minimum=%0d is_empty=%0b status=%0d",
						minimum, is_empty, status);
				end
			end else begin
				want = pending_results.pop_front();
				if (minimum !== want.minimum || is_empty !== want.is_empty ||
					status !== want.status) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch: exp min=%0d empty=%0b st=%0d, got %0d %0b %0d",
							want.minimum, want.is_empty, want.status,
							minimum, is_empty, status);
					end
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	initial begin
		int                       sent;
		int                       seq_len;
		logic                     k;
		logic signed [WORD_W-1:0] fill_val;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			issue_word(dir_rows[i].kind, dir_rows[i].operand, dir_rows[i].last_op,
				dir_rows[i].typed, dir_rows[i].res);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent < RANDOM_ITEMS / 3) begin
				send_idle_pct = 30;
				recv_stall_pct = 56;
			end else if (sent < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 56;
				recv_stall_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			if ($urandom_range(0, 99) < 85) begin
				seq_len = $urandom_range(1, 40);
				for (int n = 0; n < seq_len; n++) begin
					k = (value_used == 0 || $urandom_range(0, 99) < 55) ? KIND_PUSH : KIND_POP;
					issue_word(k, rand_word(), n == seq_len - 1, 1'b0, '0);
					sent++;
				end
			end else begin
				issue_word(1'($urandom_range(0, 1)), rand_word(), $urandom_range(0, 9) == 0,
					1'b0, '0);
				sent++;
			end
		end

		fill_val = rand_word();
		for (int n = 0; n < DEPTH + 2; n++) begin
			issue_word(KIND_PUSH, fill_val, 1'b0, 1'b0, '0);
		end
		for (int n = 0; n < FULL_POPS; n++) begin
			issue_word(KIND_POP, rand_word(), n == FULL_POPS - 1, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
